### hdl/depth_box_deprojection_averager_unit_macros.svh
// ----------------------------------------------------------------------------
// depth box deprojection averager: assertion macros
// concurrent checks, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef DEPTH_BOX_DEPROJECTION_AVERAGER_UNIT_MACROS_SVH
`define DEPTH_BOX_DEPROJECTION_AVERAGER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define DBDA_ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DBDA_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	`DBDA_ASSERT_PROP(lbl, clk, rst_n, !(expr), msg)
`else
`define DBDA_ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define DBDA_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

### hdl/dbda_pkg.sv
// ----------------------------------------------------------------------------
// dbda_pkg
// widths, codes, reset values and shared helpers of the deprojection averager
// ----------------------------------------------------------------------------
package dbda_pkg;

	localparam int BOX_W         = 12;
	localparam int DEPTH_W       = 16;
	localparam int CFG_W         = 16;
	localparam int CFG_IDX_W     = 3;
	localparam int Z_W           = 20;
	localparam int PT_W          = 24;
	localparam int SUM_XY_W      = 29;
	localparam int SUM_Z_W       = 26;
	localparam int CNT_W         = 6;
	localparam int CORR_W        = 18;
	localparam int MAG_W         = 17;
	localparam int MAG6_W        = 19;
	localparam int NUM_W         = 39;
	localparam int DEN_W         = 19;
	localparam int AVG_COUNT_DEF = 30;

	localparam int IN_TDATA_W   = 64;
	localparam int OUT_TDATA_W  = 136;
	localparam int OUT_TUSER_W  = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PRINCIPAL_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PRINCIPAL_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NEAR_LIMIT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FAR_LIMIT   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 3'd6;

	localparam logic [CFG_W-1:0] RST_FOCAL_X     = 16'd8000;
	localparam logic [CFG_W-1:0] RST_FOCAL_Y     = 16'd8000;
	localparam logic [CFG_W-1:0] RST_PRINCIPAL_X = 16'd5120;
	localparam logic [CFG_W-1:0] RST_PRINCIPAL_Y = 16'd4480;
	localparam logic [CFG_W-1:0] RST_NEAR_LIMIT  = 16'd400;
	localparam logic [CFG_W-1:0] RST_FAR_LIMIT   = 16'd1500;
	localparam logic [CFG_W-1:0] RST_HALF_WIDTH  = 16'd400;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_WIDTH = 2'd1,
		STATUS_DEPTH = 2'd2,
		STATUS_MISS  = 2'd3
	} status_t;

	typedef struct packed {
		logic add;
		logic clear;
	} acc_ctrl_t;

	// min + (max - min) / 2, halving toward zero
	function automatic logic [BOX_W-1:0] centre(input logic [BOX_W-1:0] lo,
			input logic [BOX_W-1:0] hi);
		logic signed [BOX_W:0] diff;
		logic signed [BOX_W:0] half;
		logic signed [BOX_W:0] mid;
		diff = $signed({1'b0, hi}) - $signed({1'b0, lo});
		half = (diff + $signed({{BOX_W{1'b0}}, diff[BOX_W]})) >>> 1;
		mid  = $signed({1'b0, lo}) + half;
		return mid[BOX_W-1:0];
	endfunction

	// sign and magnitude to saturated 24 bit two's complement
	function automatic logic [PT_W-1:0] sat_pt(input logic [NUM_W-1:0] mag, input logic neg);
		logic big;
		big = |mag[NUM_W-1:PT_W-1];
		if (neg) begin
			return big ? {1'b1, {(PT_W-1){1'b0}}} : (~mag[PT_W-1:0]) + PT_W'(1);
		end
		return big ? {1'b0, {(PT_W-1){1'b1}}} : mag[PT_W-1:0];
	endfunction

endpackage

### hdl/dbda_div.sv
// ----------------------------------------------------------------------------
// dbda_div
// radix-2 restoring divider, one quotient bit per cycle, unsigned
// ----------------------------------------------------------------------------
module dbda_div #(
	parameter int NUM_W = dbda_pkg::NUM_W,
	parameter int DEN_W = dbda_pkg::DEN_W
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quot
);

	localparam int CNT_W = $clog2(NUM_W);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DEN_W:0]   trial;
	logic [DEN_W+1:0] diff;
	logic             fits;

	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		diff  = {1'b0, trial} - {2'b00, den_q};
		fits  = !diff[DEN_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= '0;
			den_q  <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], fits};
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(NUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done = done_q;
	assign quot = num_q;

endmodule

### hdl/dbda_acc.sv
// ----------------------------------------------------------------------------
// dbda_acc
// batch sums of accepted points and their count
// ----------------------------------------------------------------------------
module dbda_acc (
	input  logic                            clk,
	input  logic                            arst_n,
	input  dbda_pkg::acc_ctrl_t             ctrl,
	input  logic [dbda_pkg::PT_W-1:0]       xs,
	input  logic [dbda_pkg::PT_W-1:0]       ys,
	input  logic [dbda_pkg::Z_W-1:0]        dz,
	output logic [dbda_pkg::SUM_XY_W-1:0]   sum_x,
	output logic [dbda_pkg::SUM_XY_W-1:0]   sum_y,
	output logic [dbda_pkg::SUM_Z_W-1:0]    sum_z,
	output logic [dbda_pkg::CNT_W-1:0]      count
);

	localparam int SW = dbda_pkg::SUM_XY_W;
	localparam int PW = dbda_pkg::PT_W;

	logic [SW-1:0]                   sum_x_q;
	logic [SW-1:0]                   sum_y_q;
	logic [dbda_pkg::SUM_Z_W-1:0]    sum_z_q;
	logic [dbda_pkg::CNT_W-1:0]      count_q;
	logic [SW:0]                     nx;
	logic [SW:0]                     ny;

	function automatic logic [SW-1:0] sat_sum(input logic [SW:0] t);
		if (t[SW] != t[SW-1]) begin
			return t[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		end
		return t[SW-1:0];
	endfunction

	always_comb begin
		nx = {{(SW+1-PW){xs[PW-1]}}, xs} + {sum_x_q[SW-1], sum_x_q};
		ny = {{(SW+1-PW){ys[PW-1]}}, ys} + {sum_y_q[SW-1], sum_y_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
			count_q <= '0;
		end else if (ctrl.clear) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
			count_q <= '0;
		end else if (ctrl.add) begin
			sum_x_q <= sat_sum(nx);
			sum_y_q <= sat_sum(ny);
			sum_z_q <= sum_z_q + {{(dbda_pkg::SUM_Z_W-dbda_pkg::Z_W){1'b0}}, dz};
			count_q <= count_q + dbda_pkg::CNT_W'(1);
		end
	end

	assign sum_x = sum_x_q;
	assign sum_y = sum_y_q;
	assign sum_z = sum_z_q;
	assign count = count_q;

endmodule

### hdl/depth_box_deprojection_averager_unit.sv
// ----------------------------------------------------------------------------
// depth_box_deprojection_averager_unit
// back-projects a box centre with its depth to x, y, z, gates it and averages
// batches of accepted points
// ----------------------------------------------------------------------------
// path: a detected box passes PREP, MUL, DIV_PT, EVAL, CHECK and FINISH, adding
//   DIV_AVG when the item closes a batch; a box not detected skips to FINISH
// throughput: one item at a time; the next input is taken the cycle after the
//   result is loaded, and a detected box waits on the 39-step divider
// reset: arst_n clears sums, count and handshakes; registers return to defaults
// ----------------------------------------------------------------------------
`include "depth_box_deprojection_averager_unit_macros.svh"

module depth_box_deprojection_averager_unit #(
	parameter int AVG_COUNT = dbda_pkg::AVG_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// box_xmin, box_xmax, box_ymin, box_ymax, depth_mm
	input  logic [dbda_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// point_x, point_y, point_z, average_x, average_y, average_z
	output logic [dbda_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// status, average_valid
	output logic [dbda_pkg::OUT_TUSER_W-1:0]    m_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic                                cfg_we,
	input  logic [dbda_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dbda_pkg::CFG_W-1:0]          cfg_data
);

	localparam int BW  = dbda_pkg::BOX_W;
	localparam int DW  = dbda_pkg::DEPTH_W;
	localparam int CW  = dbda_pkg::CFG_W;
	localparam int NW  = dbda_pkg::NUM_W;
	localparam int PW  = dbda_pkg::PT_W;
	localparam int ZW  = dbda_pkg::Z_W;
	localparam int SW  = dbda_pkg::SUM_XY_W;
	localparam int MW  = dbda_pkg::MAG_W;
	localparam int M6W = dbda_pkg::MAG6_W;
	localparam int RW  = dbda_pkg::CORR_W;
	localparam int ENW = dbda_pkg::DEN_W;
	localparam logic [dbda_pkg::CNT_W-1:0] AVG_CNT = AVG_COUNT[dbda_pkg::CNT_W-1:0];
	localparam logic [ENW-1:0]             AVG_DEN = AVG_COUNT[ENW-1:0];

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_MUL,
		ST_DIV_PT,
		ST_EVAL,
		ST_CHECK,
		ST_DIV_AVG,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [CW-1:0] focal_x_q, focal_y_q, principal_x_q, principal_y_q;
	logic [CW-1:0] near_q, far_q, half_width_q;

	logic [BW-1:0]  xmin_q, xmax_q, ymin_q, ymax_q;
	logic [DW-1:0]  depth_q;
	logic           neg_x_q, neg_y_q, neg_ax_q, neg_ay_q;
	logic [MW-1:0]  mag_x_q;
	logic [M6W-1:0] mag_y6_q;
	logic [ENW-1:0] den_x_q, den_y_q;

	dbda_pkg::status_t res_status_q;
	logic [PW-1:0]  res_px_q, res_py_q, res_ax_q, res_ay_q;
	logic [ZW-1:0]  res_pz_q, res_az_q;
	logic           res_avg_q;

	logic                                  m_tvalid_q;
	logic [dbda_pkg::OUT_TDATA_W-1:0]      m_tdata_q;
	logic [dbda_pkg::OUT_TUSER_W-1:0]      m_tuser_q;

	logic [BW-1:0]            cx, cy;
	logic                     detect;
	logic signed [RW-1:0]     corr_x, corr_y, abs_x, abs_y;
	logic [MW-1:0]            mag_y;
	logic [CW-1:0]            fx_nz, fy_nz;
	logic [DW+MW-1:0]         prod_x;
	logic [DW+M6W-1:0]        prod_y;
	logic [PW-1:0]            xs, ys;
	logic                     depth_ok, width_ok;
	dbda_pkg::status_t        status_next;
	logic [SW-1:0]            mag_sx, mag_sy;
	logic                     batch;

	logic                     div_start;
	logic [NW-1:0]            num_x, num_y, num_z;
	logic [ENW-1:0]           den_x, den_y, den_z;
	logic                     div_x_done, div_y_done, div_z_done;
	logic [NW-1:0]            qx, qy, qz;

	dbda_pkg::acc_ctrl_t          acc_ctrl;
	logic [SW-1:0]                acc_sum_x, acc_sum_y;
	logic [dbda_pkg::SUM_Z_W-1:0] acc_sum_z;
	logic [dbda_pkg::CNT_W-1:0]   acc_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q     <= dbda_pkg::RST_FOCAL_X;
			focal_y_q     <= dbda_pkg::RST_FOCAL_Y;
			principal_x_q <= dbda_pkg::RST_PRINCIPAL_X;
			principal_y_q <= dbda_pkg::RST_PRINCIPAL_Y;
			near_q        <= dbda_pkg::RST_NEAR_LIMIT;
			far_q         <= dbda_pkg::RST_FAR_LIMIT;
			half_width_q  <= dbda_pkg::RST_HALF_WIDTH;
		end else if (cfg_we) begin
			case (cfg_index)
				dbda_pkg::CFG_FOCAL_X:     focal_x_q     <= cfg_data;
				dbda_pkg::CFG_FOCAL_Y:     focal_y_q     <= cfg_data;
				dbda_pkg::CFG_PRINCIPAL_X: principal_x_q <= cfg_data;
				dbda_pkg::CFG_PRINCIPAL_Y: principal_y_q <= cfg_data;
				dbda_pkg::CFG_NEAR_LIMIT:  near_q        <= cfg_data;
				dbda_pkg::CFG_FAR_LIMIT:   far_q         <= cfg_data;
				dbda_pkg::CFG_HALF_WIDTH:  half_width_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cx     = dbda_pkg::centre(xmin_q, xmax_q);
		cy     = dbda_pkg::centre(ymin_q, ymax_q);
		detect = ((cx != '0) && (cy != '0)) || (cx > cy);
		corr_x = $signed({2'b00, cx, 4'b0000}) - $signed({2'b00, principal_x_q});
		corr_y = $signed({2'b00, cy, 4'b0000}) - $signed({2'b00, principal_y_q});
		abs_x  = corr_x[RW-1] ? -corr_x : corr_x;
		abs_y  = corr_y[RW-1] ? -corr_y : corr_y;
		mag_y  = abs_y[MW-1:0];
		fx_nz  = (focal_x_q == '0) ? CW'(1) : focal_x_q;
		fy_nz  = (focal_y_q == '0) ? CW'(1) : focal_y_q;

		prod_x = depth_q * mag_x_q;
		prod_y = depth_q * mag_y6_q;

		xs       = dbda_pkg::sat_pt(qx, neg_x_q);
		ys       = dbda_pkg::sat_pt(qy, neg_y_q);
		depth_ok = (depth_q > near_q) && (depth_q <= far_q);
		width_ok = qx < {{(NW-CW-4){1'b0}}, half_width_q, 4'b0000};
		if (!depth_ok) begin
			status_next = dbda_pkg::STATUS_DEPTH;
		end else if (!width_ok) begin
			status_next = dbda_pkg::STATUS_WIDTH;
		end else begin
			status_next = dbda_pkg::STATUS_OK;
		end

		mag_sx = acc_sum_x[SW-1] ? (~acc_sum_x) + SW'(1) : acc_sum_x;
		mag_sy = acc_sum_y[SW-1] ? (~acc_sum_y) + SW'(1) : acc_sum_y;
		batch  = (acc_count == AVG_CNT);

		div_start = 1'b0;
		num_x     = {{(NW-DW-MW-4){1'b0}}, prod_x, 4'b0000};
		num_y     = {prod_y, 4'b0000};
		num_z     = '0;
		den_x     = den_x_q;
		den_y     = den_y_q;
		den_z     = AVG_DEN;
		case (state_q)
			ST_MUL: begin
				div_start = 1'b1;
			end
			ST_CHECK: begin
				div_start = batch;
				num_x     = {{(NW-SW){1'b0}}, mag_sx};
				num_y     = {{(NW-SW){1'b0}}, mag_sy};
				num_z     = {{(NW-dbda_pkg::SUM_Z_W){1'b0}}, acc_sum_z};
				den_x     = AVG_DEN;
				den_y     = AVG_DEN;
			end
			default: ;
		endcase

		acc_ctrl.add   = (state_q == ST_EVAL) && (status_next == dbda_pkg::STATUS_OK);
		acc_ctrl.clear = (state_q == ST_CHECK) && batch;
	end

	dbda_div #(.NUM_W(NW), .DEN_W(ENW)) u_div_x (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(num_x), .den(den_x),
		.done(div_x_done), .quot(qx)
	);

	dbda_div #(.NUM_W(NW), .DEN_W(ENW)) u_div_y (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(num_y), .den(den_y),
		.done(div_y_done), .quot(qy)
	);

	dbda_div #(.NUM_W(NW), .DEN_W(ENW)) u_div_z (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(num_z), .den(den_z),
		.done(div_z_done), .quot(qz)
	);

	dbda_acc u_acc (
		.clk(clk), .arst_n(arst_n), .ctrl(acc_ctrl), .xs(xs), .ys(ys),
		.dz({depth_q, 4'b0000}), .sum_x(acc_sum_x), .sum_y(acc_sum_y),
		.sum_z(acc_sum_z), .count(acc_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			xmin_q       <= '0;
			xmax_q       <= '0;
			ymin_q       <= '0;
			ymax_q       <= '0;
			depth_q      <= '0;
			neg_x_q      <= 1'b0;
			neg_y_q      <= 1'b0;
			neg_ax_q     <= 1'b0;
			neg_ay_q     <= 1'b0;
			mag_x_q      <= '0;
			mag_y6_q     <= '0;
			den_x_q      <= '0;
			den_y_q      <= '0;
			res_status_q <= dbda_pkg::STATUS_OK;
			res_px_q     <= '0;
			res_py_q     <= '0;
			res_pz_q     <= '0;
			res_ax_q     <= '0;
			res_ay_q     <= '0;
			res_az_q     <= '0;
			res_avg_q    <= 1'b0;
			m_tvalid_q   <= 1'b0;
			m_tdata_q    <= '0;
			m_tuser_q    <= '0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != ST_FINISH)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						xmin_q    <= s_tdata[11:0];
						xmax_q    <= s_tdata[23:12];
						ymin_q    <= s_tdata[35:24];
						ymax_q    <= s_tdata[47:36];
						depth_q   <= s_tdata[63:48];
						res_avg_q <= 1'b0;
						res_ax_q  <= '0;
						res_ay_q  <= '0;
						res_az_q  <= '0;
						state_q   <= ST_PREP;
					end
				end
				ST_PREP: begin
					neg_x_q  <= corr_x[RW-1];
					neg_y_q  <= corr_y[RW-1];
					mag_x_q  <= abs_x[MW-1:0];
					mag_y6_q <= {mag_y, 2'b00} + {1'b0, mag_y, 1'b0};
					den_x_q  <= {{(ENW-CW){1'b0}}, fx_nz};
					den_y_q  <= {1'b0, fy_nz, 2'b00} + {{(ENW-CW){1'b0}}, fy_nz};
					if (detect) begin
						state_q <= ST_MUL;
					end else begin
						res_status_q <= dbda_pkg::STATUS_MISS;
						res_px_q     <= '0;
						res_py_q     <= '0;
						res_pz_q     <= '0;
						state_q      <= ST_FINISH;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV_PT;
				end
				ST_DIV_PT: begin
					if (div_x_done) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					res_status_q <= status_next;
					res_px_q     <= xs;
					res_py_q     <= ys;
					res_pz_q     <= {depth_q, 4'b0000};
					state_q      <= ST_CHECK;
				end
				ST_CHECK: begin
					if (batch) begin
						res_avg_q <= 1'b1;
						neg_ax_q  <= acc_sum_x[SW-1];
						neg_ay_q  <= acc_sum_y[SW-1];
						state_q   <= ST_DIV_AVG;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_DIV_AVG: begin
					if (div_x_done) begin
						res_ax_q <= dbda_pkg::sat_pt(qx, neg_ax_q);
						res_ay_q <= dbda_pkg::sat_pt(qy, neg_ay_q);
						res_az_q <= qz[ZW-1:0];
						state_q  <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {res_az_q, res_ay_q, res_ax_q, res_pz_q, res_py_q,
							res_px_q};
						m_tuser_q  <= {res_avg_q, res_status_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`DBDA_ASSERT_PROP(a_one_at_a_time, clk, arst_n,
		s_tvalid && s_tready |=> !s_tready, "input taken while busy")
	`DBDA_ASSERT_NEVER(a_div_lockstep, clk, arst_n,
		(div_x_done != div_y_done) || (div_x_done != div_z_done), "dividers out of step")
	`DBDA_ASSERT_NEVER(a_count_range, clk, arst_n, acc_count > AVG_CNT, "batch count past limit")
	`DBDA_ASSERT_PROP(a_clear_on_batch, clk, arst_n,
		acc_ctrl.clear |=> acc_count == '0, "sums not cleared after batch")
	`DBDA_ASSERT_PROP(a_avg_only_ok, clk, arst_n,
		m_tvalid && m_tuser[2] |-> m_tuser[1:0] == dbda_pkg::STATUS_OK,
		"average on rejected point")

endmodule
